/* hdl/tbs_pkg.sv */
// ----------------------------------------------------------------------------
// tbs_pkg
// Shared types and constants for the token bucket shaper.
// ----------------------------------------------------------------------------
package tbs_pkg;

    localparam int ID_W      = 16;
    localparam int NEED_W    = 10;
    localparam int LEVEL_W   = 10;
    localparam int QLEVEL_W  = 5;
    localparam int CODE_W    = 3;

    localparam logic [LEVEL_W-1:0] DEPTH_RESET = 10'd10;

    typedef enum logic [CODE_W-1:0] {
        EV_DROP_NEED        = 3'd0,
        EV_DROP_FULL        = 3'd1,
        EV_QUEUED           = 3'd2,
        EV_QUEUED_PASSED    = 3'd3,
        EV_TOKEN_DROP       = 3'd4,
        EV_TOKEN_ADD        = 3'd5,
        EV_TOKEN_ADD_PASSED = 3'd6
    } event_code_t;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [NEED_W-1:0] need;
    } wait_entry_t;

    // queue control from the shaper datapath
    typedef struct packed {
        logic        push;
        logic        pop;
        wait_entry_t entry;
    } queue_ctl_t;

    // queue status back to the datapath
    typedef struct packed {
        logic        empty;
        logic        full;
        wait_entry_t head;
    } queue_stat_t;

endpackage

/* hdl/tbs_if.sv */
// ----------------------------------------------------------------------------
// tbs_if
// Valid/ready channels for shaper events and shaper results.
// ----------------------------------------------------------------------------
interface tbs_in_if
    import tbs_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              func;
    logic [ID_W-1:0]   packet_id;
    logic [NEED_W-1:0] tokens_needed;

    modport source (output valid, output func, output packet_id, output tokens_needed,
                    input ready);
    modport sink   (input valid, input func, input packet_id, input tokens_needed,
                    output ready);
endinterface

interface tbs_out_if
    import tbs_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [CODE_W-1:0]   event_code;
    logic                passed_valid;
    logic [ID_W-1:0]     passed_id;
    logic [LEVEL_W-1:0]  token_level;
    logic [QLEVEL_W-1:0] queue_level;

    modport source (output valid, output event_code, output passed_valid,
                    output passed_id, output token_level, output queue_level,
                    input ready);
    modport sink   (input valid, input event_code, input passed_valid,
                    input passed_id, input token_level, input queue_level,
                    output ready);
endinterface

/* hdl/token_bucket_shaper_core.sv */
// ----------------------------------------------------------------------------
// token_bucket_shaper_core
// Token bucket shaper with a waiting packet FIFO.
// ----------------------------------------------------------------------------
// One event (packet arrival or token tick) is accepted every clock cycle
// while the result side is not stalled; it passes the input register, then
// the result register, and the rate is set by the combinational decision
// logic between them together with the FIFO head register, which always
// holds the current head packet. The FIFO memory needs no clearing after
// reset. Write bucket_depth only while no events are in flight.
module token_bucket_shaper_core
    import tbs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [LEVEL_W-1:0] cfg_wdata,
    tbs_in_if.sink             arrival,
    tbs_out_if.source          result
);

    localparam int FW = $clog2(QUEUE_DEPTH+1);

    // configuration and bucket state
    logic [LEVEL_W-1:0]  depth_reg;
    logic [LEVEL_W-1:0]  tokens_reg, tokens_next;

    // input register
    logic                s1_valid_reg;
    logic                s1_func_reg;
    logic [ID_W-1:0]     s1_id_reg;
    logic [NEED_W-1:0]   s1_need_reg;
    logic                s1_fire;

    // result register
    logic                out_valid_reg;
    event_code_t         out_code_reg, out_code_next;
    logic                out_passed_reg, out_passed_next;
    logic [ID_W-1:0]     out_id_reg, out_id_next;
    logic [LEVEL_W-1:0]  out_tokens_reg;
    logic [QLEVEL_W-1:0] out_qlevel_reg;

    queue_ctl_t          qctl;
    queue_stat_t         qstat;
    logic [FW-1:0]       fill;
    logic [FW-1:0]       fill_after;
    logic [LEVEL_W-1:0]  tokens_inc;
    logic                push_req, pop_req;

    tbs_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (qctl),
        .stat  (qstat),
        .fill  (fill)
    );

    assign s1_fire       = s1_valid_reg && (!out_valid_reg || result.ready);
    assign arrival.ready = !s1_valid_reg || s1_fire;
    assign tokens_inc    = tokens_reg + LEVEL_W'(1);

    // decision for the transaction held in the input register
    always_comb
    begin
        tokens_next     = tokens_reg;
        out_code_next   = EV_DROP_NEED;
        out_passed_next = 1'b0;
        out_id_next     = '0;
        push_req        = 1'b0;
        pop_req         = 1'b0;
        if (!s1_func_reg)
        begin
            if (s1_need_reg > depth_reg)
            begin
                out_code_next = EV_DROP_NEED;
            end
            else if (qstat.full)
            begin
                out_code_next = EV_DROP_FULL;
            end
            else if (qstat.empty && (tokens_reg >= s1_need_reg))
            begin
                tokens_next     = tokens_reg - s1_need_reg;
                out_passed_next = 1'b1;
                out_id_next     = s1_id_reg;
                out_code_next   = EV_QUEUED_PASSED;
            end
            else
            begin
                push_req      = 1'b1;
                out_code_next = EV_QUEUED;
            end
        end
        else
        begin
            if (tokens_reg < depth_reg)
            begin
                tokens_next   = tokens_inc;
                out_code_next = EV_TOKEN_ADD;
                if (!qstat.empty && (qstat.head.need <= tokens_inc))
                begin
                    tokens_next     = tokens_inc - qstat.head.need;
                    out_passed_next = 1'b1;
                    out_id_next     = qstat.head.id;
                    pop_req         = 1'b1;
                    out_code_next   = EV_TOKEN_ADD_PASSED;
                end
            end
            else
            begin
                out_code_next = EV_TOKEN_DROP;
            end
        end
    end

    assign qctl.push       = s1_fire && push_req;
    assign qctl.pop        = s1_fire && pop_req;
    assign qctl.entry.id   = s1_id_reg;
    assign qctl.entry.need = s1_need_reg;

    assign fill_after = push_req ? fill + FW'(1) :
                        pop_req  ? fill - FW'(1) : fill;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg     <= DEPTH_RESET;
            tokens_reg    <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                depth_reg <= cfg_wdata;
            end
            if (arrival.ready)
            begin
                s1_valid_reg <= arrival.valid;
            end
            if (s1_fire)
            begin
                tokens_reg    <= tokens_next;
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (arrival.valid && arrival.ready)
        begin
            s1_func_reg <= arrival.func;
            s1_id_reg   <= arrival.packet_id;
            s1_need_reg <= arrival.tokens_needed;
        end
        if (s1_fire)
        begin
            out_code_reg   <= out_code_next;
            out_passed_reg <= out_passed_next;
            out_id_reg     <= out_id_next;
            out_tokens_reg <= tokens_next;
            out_qlevel_reg <= QLEVEL_W'(fill_after);
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.event_code   = out_code_reg;
    assign result.passed_valid = out_passed_reg;
    assign result.passed_id    = out_id_reg;
    assign result.token_level  = out_tokens_reg;
    assign result.queue_level  = out_qlevel_reg;

`ifndef NO_ASSERTIONS
    a_push_pop_excl : assert property (@(posedge clk) disable iff (!rst_n)
        qctl.push |-> !qctl.pop)
        else $error("queue push and pop in the same cycle");

    a_pop_nonempty : assert property (@(posedge clk) disable iff (!rst_n)
        qctl.pop |-> !qstat.empty)
        else $error("pop from empty queue");

    a_fill_bound : assert property (@(posedge clk) disable iff (!rst_n)
        fill <= FW'(QUEUE_DEPTH))
        else $error("queue fill beyond depth");

    a_pass_code : assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.passed_valid ==
            ((result.event_code == EV_QUEUED_PASSED) ||
             (result.event_code == EV_TOKEN_ADD_PASSED))))
        else $error("passed flag disagrees with event code");
`endif

endmodule

/* hdl/tbs_queue.sv */
// ----------------------------------------------------------------------------
// tbs_queue
// Waiting FIFO of packets; the head entry is kept in a read register.
// ----------------------------------------------------------------------------
module tbs_queue
    import tbs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  queue_ctl_t                         ctl,
    output queue_stat_t                        stat,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]   fill
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FW = $clog2(QUEUE_DEPTH+1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(QUEUE_DEPTH - 1);
    localparam logic [FW-1:0] FULL_FILL = FW'(QUEUE_DEPTH);

    wait_entry_t   mem [QUEUE_DEPTH];
    wait_entry_t   head_data_reg;
    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [FW-1:0] fill_reg, fill_next;

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        fill_next = fill_reg;
        if (ctl.pop)
        begin
            head_next = (head_reg == LAST_SLOT) ? '0 : head_reg + AW'(1);
            fill_next = fill_reg - FW'(1);
        end
        if (ctl.push)
        begin
            tail_next = (tail_reg == LAST_SLOT) ? '0 : tail_reg + AW'(1);
            fill_next = fill_reg + FW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            fill_reg <= fill_next;
        end
    end

    // Head read register tracks mem[head]; bypass a write landing on the new head.
    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            mem[tail_reg] <= ctl.entry;
        end
        if (ctl.push && (tail_reg == head_next))
        begin
            head_data_reg <= ctl.entry;
        end
        else
        begin
            head_data_reg <= mem[head_next];
        end
    end

    assign stat.empty = (fill_reg == '0);
    assign stat.full  = (fill_reg >= FULL_FILL);
    assign stat.head  = head_data_reg;
    assign fill       = fill_reg;

endmodule

/* test/shaper_checker.sv */
// ----------------------------------------------------------------------------
// shaper_checker
// Watches the event and result channels of the token bucket shaper, keeps
// its own copy of the bucket and waiting queue, and compares each result
// transaction field by field against the predicted outcome.
// ----------------------------------------------------------------------------
module shaper_checker
    import tbs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [LEVEL_W-1:0] cfg_wdata,
    tbs_in_if                  arrival,
    tbs_out_if                 result,
    output int                 errors,
    output int                 outstanding,
    output int                 passed_total,
    output int                 full_drops
);

    typedef struct {
        event_code_t          code;
        logic                 pv;
        logic [ID_W-1:0]      pid;
        logic [LEVEL_W-1:0]   level;
        logic [QLEVEL_W-1:0]  qlevel;
    } shaper_outcome_t;

    logic [LEVEL_W-1:0] depth_reg;
    logic [LEVEL_W-1:0] token_level;
    wait_entry_t        waiting[$];
    shaper_outcome_t    predicted[$];

    function automatic shaper_outcome_t shape_event(input logic func,
                                                    input logic [ID_W-1:0] pkt_id,
                                                    input logic [NEED_W-1:0] pkt_need);
        shaper_outcome_t o;
        wait_entry_t     head;
        o.pv  = 1'b0;
        o.pid = '0;
        if (!func)
        begin
            if (pkt_need > depth_reg)
                o.code = EV_DROP_NEED;
            else if (waiting.size() >= QUEUE_DEPTH)
                o.code = EV_DROP_FULL;
            else if (waiting.size() == 0 && token_level >= pkt_need)
            begin
                token_level = token_level - pkt_need;
                o.pv   = 1'b1;
                o.pid  = pkt_id;
                o.code = EV_QUEUED_PASSED;
            end
            else
            begin
                // a non-empty queue is never bypassed, even with tokens to spare
                waiting.push_back('{id: pkt_id, need: pkt_need});
                o.code = EV_QUEUED;
            end
        end
        else if (token_level < depth_reg)
        begin
            token_level = token_level + 1'b1;
            o.code = EV_TOKEN_ADD;
            if (waiting.size() != 0 && waiting[0].need <= token_level)
            begin
                head = waiting.pop_front();
                token_level = token_level - head.need;
                o.pv   = 1'b1;
                o.pid  = head.id;
                o.code = EV_TOKEN_ADD_PASSED;
            end
        end
        else
        begin
            // also covers a level left above a lowered depth
            o.code = EV_TOKEN_DROP;
        end
        o.level  = token_level;
        o.qlevel = QLEVEL_W'(waiting.size());
        return o;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        shaper_outcome_t want;
        if (!rst_n)
        begin
            depth_reg    = DEPTH_RESET;
            token_level  = '0;
            waiting.delete();
            predicted.delete();
            errors       = 0;
            outstanding  = 0;
            passed_total = 0;
            full_drops   = 0;
        end
        else
        begin
            if (cfg_we)
                depth_reg = cfg_wdata;
            if (arrival.valid && arrival.ready)
                predicted.push_back(shape_event(arrival.func, arrival.packet_id,
                                                arrival.tokens_needed));
            if (result.valid && result.ready)
            begin
                if (predicted.size() == 0)
                begin
                    $error("unexpected result transaction: event_code %0d",
                           result.event_code);
                    errors++;
                end
                else
                begin
                    want = predicted.pop_front();
                    check_field("event_code", want.code, result.event_code);
                    check_field("passed_valid", want.pv, result.passed_valid);
                    check_field("passed_id", want.pid, result.passed_id);
                    check_field("token_level", want.level, result.token_level);
                    check_field("queue_level", want.qlevel, result.queue_level);
                    if (want.pv)
                        passed_total++;
                    if (want.code == EV_DROP_FULL)
                        full_drops++;
                end
            end
            outstanding = predicted.size();
        end
    end

endmodule

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the token bucket shaper: a directed opening, then random
// arrivals and ticks over several bucket depths with random idling on both
// channels, a long receiver stall, and a checker that predicts every result.
// ----------------------------------------------------------------------------
module testbench
    import tbs_pkg::*;
();

    localparam int Q_DEPTH        = 16;
    localparam int GAP_MAX        = 13;
    localparam int RX_HOLD_AT     = 200;
    localparam int RX_HOLD_CYCLES = 150;
    localparam int SETTLE_CYCLES  = 4;
    localparam int DRAIN_CYCLES   = 10;
    localparam int WATCHDOG_LIMIT = 2000;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_we;
    logic [LEVEL_W-1:0] cfg_wdata;

    tbs_in_if  arrival();
    tbs_out_if result();

    int errors;
    int outstanding;
    int passed_total;
    int full_drops;

    logic [LEVEL_W-1:0] depth_now;
    bit                 no_gaps;
    int                 sent;
    int                 ticks_sent;
    int                 depth_writes;
    int                 idle_cycles;

    token_bucket_shaper_core #(
        .QUEUE_DEPTH(Q_DEPTH)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .arrival   (arrival),
        .result    (result)
    );

    shaper_checker #(
        .QUEUE_DEPTH(Q_DEPTH)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .arrival      (arrival),
        .result       (result),
        .errors       (errors),
        .outstanding  (outstanding),
        .passed_total (passed_total),
        .full_drops   (full_drops)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // offer one event and hold it until the transaction completes
    task automatic send_event(input logic func, input logic [ID_W-1:0] pkt_id,
                              input logic [NEED_W-1:0] pkt_need);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, GAP_MAX);
        if (gap != 0)
        begin
            arrival.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        arrival.valid         <= 1'b1;
        arrival.func          <= func;
        arrival.packet_id     <= pkt_id;
        arrival.tokens_needed <= pkt_need;
        @(posedge clk);
        while (!arrival.ready)
            @(posedge clk);
        sent++;
        if (func)
            ticks_sent++;
        @(negedge clk);
    endtask

    task automatic random_event(input int tick_pct);
        logic              func;
        logic [ID_W-1:0]   pkt_id;
        logic [NEED_W-1:0] pkt_need;
        int                r;
        int                cap;
        cap    = (depth_now < 12) ? depth_now : 12;
        func   = ($urandom_range(0, 99) < tick_pct);
        pkt_id = ID_W'($urandom);
        r      = $urandom_range(0, 9);
        // needs far above the level would park at the head for good, so large
        // needs mostly land above the depth and get dropped
        if (r == 6)
            pkt_need = '0;
        else if (r == 7 && depth_now <= 16)
            pkt_need = depth_now;
        else if (r == 8 && depth_now < 1023)
            pkt_need = NEED_W'($urandom_range(depth_now + 1, 1023));
        else if (r == 9 && depth_now < 16)
            pkt_need = NEED_W'($urandom_range(0, 1023));
        else
            pkt_need = NEED_W'($urandom_range(0, cap));
        send_event(func, pkt_id, pkt_need);
    endtask

    // wait for every pending result, then write the depth while idle
    task automatic settle_and_configure(input logic [LEVEL_W-1:0] depth);
        arrival.valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= depth;
        @(negedge clk);
        cfg_we    <= 1'b0;
        depth_now = depth;
        depth_writes++;
    endtask

    task automatic run_phase(input logic [LEVEL_W-1:0] depth, input int count,
                             input int tick_pct, input bit fast);
        settle_and_configure(depth);
        no_gaps = fast;
        repeat (count) random_event(tick_pct);
    endtask

    initial
    begin
        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_wdata             = '0;
        arrival.valid         = 1'b0;
        arrival.func          = 1'b0;
        arrival.packet_id     = '0;
        arrival.tokens_needed = '0;
        depth_now             = DEPTH_RESET;
        no_gaps               = 1'b0;
        sent                  = 0;
        ticks_sent            = 0;
        depth_writes          = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed opening at the reset depth
        send_event(1'b1, ID_W'($urandom), NEED_W'($urandom));
        send_event(1'b0, 16'h0000, 10'd0);
        send_event(1'b0, 16'h5a5a, 10'd11);
        send_event(1'b0, ID_W'($urandom), 10'd1023);
        send_event(1'b0, 16'hffff, 10'd10);
        send_event(1'b0, 16'h1234, 10'd0);
        // fill the waiting queue; the last one finds it full
        repeat (Q_DEPTH - 1)
            send_event(1'b0, ID_W'($urandom), NEED_W'($urandom_range(0, 3)));

        run_phase(10'd10, 170, 60, 1'b0);
        run_phase(10'd0, 30, 50, 1'b1);
        run_phase(10'd1023, 40, 90, 1'b0);
        // level built up above is now over the depth
        run_phase(10'd4, 70, 50, 1'b0);
        run_phase(10'd1, 50, 50, 1'b1);
        run_phase(10'd300, 70, 40, 1'b0);

        arrival.valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Sent %0d events (%0d token ticks) over %0d depth settings from 0 to 1023.",
                 sent, ticks_sent, depth_writes);
        $display("%0d packets passed on, %0d dropped on a full queue, one %0d-cycle stall.",
                 passed_total, full_drops, RX_HOLD_CYCLES);
        if (errors == 0)
            $display("** token_bucket_shaper_core: PASSED **");
        else
            $display("** token_bucket_shaper_core: FAILED **");
        $finish;
    end

    // result side backpressure, with one long hold-off partway through
    initial
    begin : rx_side
        int gap;
        int results_seen;
        result.ready = 1'b0;
        results_seen = 0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            gap = no_gaps ? 0 : $urandom_range(0, GAP_MAX);
            if (results_seen == RX_HOLD_AT)
                gap = RX_HOLD_CYCLES;
            if (gap != 0)
            begin
                result.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            result.ready <= 1'b1;
            @(posedge clk);
            while (!result.valid)
                @(posedge clk);
            results_seen++;
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((arrival.valid && arrival.ready) || (result.valid && result.ready))
            idle_cycles <= 0;
        else if (idle_cycles + 1 >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("** token_bucket_shaper_core: FAILED **");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule

/* sim.f */
hdl/tbs_pkg.sv
hdl/tbs_if.sv
hdl/tbs_queue.sv
hdl/token_bucket_shaper_core.sv
test/shaper_checker.sv
test/testbench.sv
